// File: sv/lru_replacement_tracker_top_defines.svh
// assertion macros for the lru replacement tracker
// no dependencies; taken in by the modules that carry assertions
`ifndef LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LRT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LRT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define LRT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/lrt_pkg.sv
// shared types and constants for the lru replacement tracker
// no dependencies; used by lrt_cell and lru_replacement_tracker_top
package lrt_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned KeyBitsDef = 16;
  localparam int unsigned OccW       = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_VICTIM = 2'd1,
    KIND_ERASE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // one-hot operation strobe broadcast to every cell
  typedef struct packed {
    logic ins_hit;
    logic append;
    logic victim;
    logic erase;
  } cell_ctl_t;

endpackage

// File: sv/lru_replacement_tracker_top.sv
// lru replacement tracker: a chain of ENTRIES cells, least recent key in cell 0
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while the output is not stalled; a single pass of key match and neighbour shift
// the next item is taken while the current result waits, unless it is stalled
// reset clears all valid bits and the count; key storage is not reset
module lru_replacement_tracker_top import lrt_pkg::*; #(
  parameter int unsigned ENTRIES  = EntriesDef,
  parameter int unsigned KEY_BITS = KeyBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [KEY_BITS-1:0] victim_key_o,
  output logic [OccW-1:0]     occupancy_o
);

  `include "lru_replacement_tracker_top_defines.svh"

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] key_vec [ENTRIES];
  logic [ENTRIES-1:0]  valid_vec;
  logic [ENTRIES-1:0]  hit_vec;
  logic [ENTRIES:0]    carry_vec;

  cell_ctl_t           ctl;
  logic                accept, found, full, empty;
  logic [CntW-1:0]     count_q, count_d;
  status_e             status;
  logic [KEY_BITS-1:0] victim;
  logic [CntW+OccW-1:0] occ_wide;

  logic                out_valid_q;
  status_e             status_q;
  logic [KEY_BITS-1:0] victim_q;
  logic [OccW-1:0]     occ_q;

  assign carry_vec[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] nkey;
    logic                nvalid, pvalid;
    if (i == ENTRIES - 1) begin : g_last
      assign nkey   = '0;
      assign nvalid = 1'b0;
    end else begin : g_mid
      assign nkey   = key_vec[i+1];
      assign nvalid = valid_vec[i+1];
    end
    if (i == 0) begin : g_first
      assign pvalid = 1'b1;
    end else begin : g_rest
      assign pvalid = valid_vec[i-1];
    end
    lrt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_i       (key_i),
      .next_key_i  (nkey),
      .next_valid_i(nvalid),
      .prev_valid_i(pvalid),
      .carry_i     (carry_vec[i]),
      .carry_o     (carry_vec[i+1]),
      .key_o       (key_vec[i]),
      .valid_o     (valid_vec[i]),
      .hit_o       (hit_vec[i])
    );
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign found      = |hit_vec;
  assign full       = valid_vec[ENTRIES-1];
  assign empty      = !valid_vec[0];

  always_comb begin
    ctl     = '0;
    status  = ST_OK;
    victim  = '0;
    count_d = count_q;
    if (accept) begin
      case (kind_e'(kind_i))
        KIND_INSERT: begin
          if (found) begin
            ctl.ins_hit = 1'b1;
          end else if (full) begin
            status = ST_FULL;
          end else begin
            ctl.append = 1'b1;
            count_d    = count_q + CntW'(1);
          end
        end
        KIND_VICTIM: begin
          if (empty) begin
            status = ST_MISS;
          end else begin
            ctl.victim = 1'b1;
            victim     = key_vec[0];
            count_d    = count_q - CntW'(1);
          end
        end
        KIND_ERASE: begin
          if (!found) begin
            status = ST_MISS;
          end else begin
            ctl.erase = 1'b1;
            count_d   = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign occ_wide = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      victim_q <= victim;
      occ_q    <= occ_wide[OccW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign victim_key_o = victim_q;
  assign occupancy_o  = occ_q;

  `LRT_ASSERT_IMP(a_count_matches_valid, clk_i, rst_ni, 1'b1, $countones(valid_vec) == int'(count_q), "count and valid bits disagree")
  `LRT_ASSERT_IMP(a_single_hit, clk_i, rst_ni, 1'b1, $onehot0(hit_vec), "key held in more than one cell")
  `LRT_ASSERT_IMP(a_valid_packed, clk_i, rst_ni, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0, "valid cells not packed from cell 0")
  `LRT_ASSERT_NXT(a_append_grows, clk_i, rst_ni, ctl.append, count_q == $past(count_q) + CntW'(1), "append did not grow the count")
  `LRT_ASSERT_IMP(a_full_status, clk_i, rst_ni, out_valid_q && (status_q == ST_FULL), count_q == CntW'(ENTRIES), "full status with free slots")

endmodule

// File: sv/lrt_cell.sv
// one slot of the recency chain: holds a key and its valid bit
// depends on lrt_pkg; instantiated in a row by lru_replacement_tracker_top
module lrt_cell import lrt_pkg::*; #(
  parameter int unsigned KEY_BITS = KeyBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  input  logic                next_valid_i,
  input  logic                prev_valid_i,
  input  logic                carry_i,
  output logic                carry_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic                valid_o,
  output logic                hit_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                valid_q, valid_d;
  logic                sel;

  assign hit_o   = valid_q && (key_q == key_i);
  assign carry_o = carry_i || hit_o;
  assign sel     = ctl_i.victim || carry_o;
  assign key_o   = key_q;
  assign valid_o = valid_q;

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    // close the gap: take the neighbour's key
    if ((ctl_i.ins_hit || ctl_i.victim || ctl_i.erase) && sel && valid_q && next_valid_i) begin
      key_d = next_key_i;
    end
    // touched key lands at the most recent end
    if (ctl_i.ins_hit && sel && valid_q && !next_valid_i) begin
      key_d = key_i;
    end
    // new key goes into the first free slot
    if (ctl_i.append && !valid_q && prev_valid_i) begin
      key_d   = key_i;
      valid_d = 1'b1;
    end
    // removal frees the tail slot
    if ((ctl_i.victim || ctl_i.erase) && valid_q && !next_valid_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule
